// ===== sv/dftn_pkg.sv =====
// Package of the fork-and-turn token node: codes, widths and the job record that the
// front part hands through the queue to the back part.
// Depends on nothing; every other file of the block takes its names from here.
package dftn_pkg;

  // Number of nodes in the system; node ids and masks stay three and eight bits wide.
  localparam int NODES = 8;
  localparam int MASK_W = 8;
  localparam int ID_W = 3;
  localparam int COUNT_W = 8;

  // Depth of the job queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;

  // Nodes that exist; bits at or above NODES are dropped from the neighbor mask.
  localparam logic [MASK_W-1:0] SPAN_MASK =
      (NODES >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((1 << NODES) - 1);

  // Input event kinds.
  localparam logic [1:0] KIND_HUNGER    = 2'd0;
  localparam logic [1:0] KIND_FORK_REQ  = 2'd1;
  localparam logic [1:0] KIND_FORK_ARR  = 2'd2;
  localparam logic [1:0] KIND_TURN_ARR  = 2'd3;

  // Notes that travel with a fork.
  localparam logic [1:0] NOTE_PLAIN = 2'd0;
  localparam logic [1:0] NOTE_ASK   = 2'd1;
  localparam logic [1:0] NOTE_TURN  = 2'd2;

  // Result actions.
  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_ACCESS  = 3'd1;
  localparam logic [2:0] ACT_REQUEST = 3'd2;
  localparam logic [2:0] ACT_FORK    = 3'd3;
  localparam logic [2:0] ACT_TURN    = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] CFG_NODE_ID   = 3'd0;
  localparam logic [2:0] CFG_NBR_MASK  = 3'd1;
  localparam logic [2:0] CFG_INIT_FORK = 3'd2;
  localparam logic [2:0] CFG_INIT_TURN = 3'd3;
  localparam logic [2:0] CFG_LIMIT     = 3'd4;

  localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(10);

  // One classified event, ready to be played out as a list of results.
  typedef struct packed {
    logic               grant;      // access mark comes first
    logic               req;        // every message is a fork request
    logic [MASK_W-1:0]  msg_mask;   // one message per set bit, ascending
    logic [MASK_W-1:0]  fork_mask;  // messages that carry a fork (otherwise a turn)
    logic [1:0]         note;       // note carried by those forks
    logic [COUNT_W-1:0] count;      // access count after the event
  } job_t;

endpackage

// ===== sv/dftn_front.sv =====
// Front part of the token node: configuration registers, per-neighbor state and the
// classifier that turns one accepted request into a job record.
// Depends on dftn_pkg.
module dftn_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [1:0]                   kind_i,
  input  logic [dftn_pkg::ID_W-1:0]    src_i,
  input  logic [1:0]                   note_i,
  input  logic                         cfg_we_i,
  input  logic [2:0]                   cfg_idx_i,
  input  logic [dftn_pkg::MASK_W-1:0]  cfg_wdata_i,
  output logic                         push_o,
  output dftn_pkg::job_t               job_o
);

  logic [dftn_pkg::ID_W-1:0]    node_id_q;
  logic [dftn_pkg::MASK_W-1:0]  nbr_mask_q;
  logic [dftn_pkg::COUNT_W-1:0] limit_q;
  logic                         hungry_q, hungry_d;
  logic [dftn_pkg::MASK_W-1:0]  held_q, held_d;
  logic [dftn_pkg::MASK_W-1:0]  turn_q, turn_d;
  logic [dftn_pkg::MASK_W-1:0]  owed_q, owed_d;
  logic [dftn_pkg::COUNT_W-1:0] count_q, count_d;

  logic [dftn_pkg::MASK_W-1:0]  nb, src_bit, held2, turn2, owed2, pass, fk;
  logic                         below_limit;

  assign nb = nbr_mask_q & dftn_pkg::SPAN_MASK &
              ~(dftn_pkg::MASK_W'(1) << node_id_q);
  assign src_bit = dftn_pkg::MASK_W'(1) << src_i;
  assign below_limit = count_q < limit_q;

  // State that a fork arrival leaves before the access check.
  assign held2 = held_q | src_bit;
  assign turn2 = turn_q | ((note_i == dftn_pkg::NOTE_TURN) ? src_bit : '0);
  assign owed2 = owed_q | ((note_i == dftn_pkg::NOTE_ASK) ? src_bit : '0);
  // Turns handed on after an access, and which of them ride inside an owed fork.
  assign pass = nb & turn2;
  assign fk = pass & owed2;

  always_comb begin
    hungry_d = hungry_q;
    held_d   = held_q;
    turn_d   = turn_q;
    owed_d   = owed_q;
    count_d  = count_q;
    job_o    = '0;
    case (kind_i)
      dftn_pkg::KIND_HUNGER: begin
        if (below_limit) begin
          if ((held_q & nb) == nb) begin
            job_o.grant = 1'b1;
            count_d = count_q + dftn_pkg::COUNT_W'(1);
          end else begin
            hungry_d = 1'b1;
            job_o.req = 1'b1;
            job_o.msg_mask = nb & ~held_q;
          end
        end
      end
      dftn_pkg::KIND_FORK_REQ: begin
        if ((nb & src_bit) != '0) begin
          if (!hungry_q || ((turn_q & src_bit) == '0)) begin
            held_d = held_q & ~src_bit;
            job_o.msg_mask = src_bit;
            job_o.fork_mask = src_bit;
            job_o.note = hungry_q ? dftn_pkg::NOTE_ASK : dftn_pkg::NOTE_PLAIN;
          end else begin
            owed_d = owed_q | src_bit;
          end
        end
      end
      dftn_pkg::KIND_FORK_ARR: begin
        if ((nb & src_bit) != '0) begin
          held_d = held2;
          turn_d = turn2;
          owed_d = owed2;
          if ((held2 & nb) == nb) begin
            job_o.grant = 1'b1;
            if (below_limit) begin
              count_d = count_q + dftn_pkg::COUNT_W'(1);
            end
            hungry_d = 1'b0;
            turn_d = turn2 & ~pass;
            owed_d = owed2 & ~fk;
            held_d = held2 & ~fk;
            job_o.msg_mask = pass;
            job_o.fork_mask = fk;
            job_o.note = dftn_pkg::NOTE_TURN;
          end
        end
      end
      default: begin
        if ((nb & src_bit) != '0) begin
          turn_d = turn_q | src_bit;
        end
      end
    endcase
    job_o.count = count_d;
  end

  assign push_o = accept_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q  <= '0;
      nbr_mask_q <= '0;
      limit_q    <= dftn_pkg::LIMIT_RESET;
      hungry_q   <= 1'b0;
      held_q     <= '0;
      turn_q     <= '0;
      owed_q     <= '0;
      count_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dftn_pkg::CFG_NODE_ID:   node_id_q  <= cfg_wdata_i[dftn_pkg::ID_W-1:0];
        dftn_pkg::CFG_NBR_MASK:  nbr_mask_q <= cfg_wdata_i;
        dftn_pkg::CFG_INIT_FORK: held_q     <= cfg_wdata_i;
        dftn_pkg::CFG_INIT_TURN: turn_q     <= cfg_wdata_i;
        dftn_pkg::CFG_LIMIT:     limit_q    <= cfg_wdata_i;
        default: ;
      endcase
    end else if (accept_i) begin
      hungry_q <= hungry_d;
      held_q   <= held_d;
      turn_q   <= turn_d;
      owed_q   <= owed_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== sv/dftn_queue.sv =====
// Short job queue that decouples the classifier from the result walker.
// Depends on dftn_pkg for the job record.
module dftn_queue #(
  parameter int DEPTH = dftn_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dftn_pkg::job_t job_i,
  input  logic           pop_i,
  output dftn_pkg::job_t head_o,
  output logic           empty_o,
  output logic           full_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dftn_pkg::job_t   mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

// ===== sv/dftn_back.sv =====
// Back part of the token node: takes one job from the queue and plays it out as a
// run of results, one per cycle, into a registered result port.
// Depends on dftn_pkg.
module dftn_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  dftn_pkg::job_t                head_i,
  output logic                          pop_o,
  output logic                          strobe_o,
  output logic [2:0]                    action_o,
  output logic [dftn_pkg::ID_W-1:0]     dest_o,
  output logic [1:0]                    payload_o,
  output logic [dftn_pkg::COUNT_W-1:0]  count_o,
  output logic                          last_o
);

  logic                         active_q, active_d;
  dftn_pkg::job_t               job_q;
  logic                         grant_q, grant_d;
  logic [dftn_pkg::MASK_W-1:0]  rem_q, rem_d, rem_next;
  logic [dftn_pkg::ID_W-1:0]    idx;
  logic                         emit, emit_last;
  logic [2:0]                   emit_act;
  logic [dftn_pkg::ID_W-1:0]    emit_dest;
  logic [1:0]                   emit_note;

  logic                         strobe_q, last_q;
  logic [2:0]                   action_q;
  logic [dftn_pkg::ID_W-1:0]    dest_q;
  logic [1:0]                   payload_q;
  logic [dftn_pkg::COUNT_W-1:0] count_q;

  // Lowest neighbor still waiting for its message.
  always_comb begin
    idx = '0;
    for (int i = dftn_pkg::MASK_W - 1; i >= 0; i--) begin
      if (rem_q[i]) begin
        idx = dftn_pkg::ID_W'(i);
      end
    end
  end
  assign rem_next = rem_q & ~(dftn_pkg::MASK_W'(1) << idx);

  assign pop_o = !active_q && !empty_i;

  always_comb begin
    active_d  = active_q;
    grant_d   = grant_q;
    rem_d     = rem_q;
    emit      = 1'b0;
    emit_last = 1'b0;
    emit_act  = dftn_pkg::ACT_NONE;
    emit_dest = '0;
    emit_note = dftn_pkg::NOTE_PLAIN;
    if (active_q) begin
      emit = 1'b1;
      if (grant_q) begin
        emit_act  = dftn_pkg::ACT_ACCESS;
        grant_d   = 1'b0;
        emit_last = (rem_q == '0);
      end else if (rem_q != '0) begin
        emit_dest = idx;
        if (job_q.req) begin
          emit_act = dftn_pkg::ACT_REQUEST;
        end else if (job_q.fork_mask[idx]) begin
          emit_act  = dftn_pkg::ACT_FORK;
          emit_note = job_q.note;
        end else begin
          emit_act = dftn_pkg::ACT_TURN;
        end
        rem_d     = rem_next;
        emit_last = (rem_next == '0);
      end else begin
        // An event with nothing to report still answers once.
        emit_last = 1'b1;
      end
      if (emit_last) begin
        active_d = 1'b0;
      end
    end else if (!empty_i) begin
      active_d = 1'b1;
      grant_d  = head_i.grant;
      rem_d    = head_i.msg_mask;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= head_i;
    end
    if (emit) begin
      action_q  <= emit_act;
      dest_q    <= emit_dest;
      payload_q <= emit_note;
      count_q   <= job_q.count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      grant_q  <= 1'b0;
      rem_q    <= '0;
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      active_q <= active_d;
      grant_q  <= grant_d;
      rem_q    <= rem_d;
      strobe_q <= emit;
      last_q   <= emit && emit_last;
    end
  end

  assign strobe_o  = strobe_q;
  assign action_o  = action_q;
  assign dest_o    = dest_q;
  assign payload_o = payload_q;
  assign count_o   = count_q;
  assign last_o    = last_q;

endmodule

// ===== sv/dining_fork_token_node.sv =====
// The first result of a request passes the job queue, the back part's job register and the
// result register; the walker gives one result per cycle and loads the next request only
// after the last result of the current one. A request gives one to eight results.
// busy rises only while the two-entry job queue is full.
// Reset (rst_ni, asynchronous, active low) clears the control state; access limit resets to 10.
// Results are strobed for one cycle each; the receiver cannot stall them.
module dining_fork_token_node #(
  parameter int QDEPTH = dftn_pkg::QUEUE_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Request channel.
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    kind_i,
  input  logic [dftn_pkg::ID_W-1:0]     source_node_i,
  input  logic [1:0]                    fork_note_i,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_idx_i,
  input  logic [dftn_pkg::MASK_W-1:0]   cfg_wdata_i,
  // Result channel.
  output logic                          res_strobe_o,
  output logic [2:0]                    action_o,
  output logic [dftn_pkg::ID_W-1:0]     dest_node_o,
  output logic [1:0]                    fork_payload_o,
  output logic [dftn_pkg::COUNT_W-1:0]  accesses_done_o,
  output logic                          last_o
);

  // The front part classifies each request as it is accepted. All per-neighbor state
  // (forks held, turns held, forks owed, hungry flag, access count) is updated at that same
  // edge unless cfg_we_i is high then; one job record captures all outgoing messages.
  logic           accept, push, pop, q_empty, q_full;
  dftn_pkg::job_t job_in, job_head;

  assign accept = start && !busy;
  assign busy   = q_full;

  dftn_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .kind_i      (kind_i),
    .src_i       (source_node_i),
    .note_i      (fork_note_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_o      (push),
    .job_o       (job_in)
  );

  // The queue lets new requests be taken while earlier ones are still being played out.
  dftn_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (pop),
    .head_o  (job_head),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // The back part emits the access mark first and then one message per neighbor in the
  // job, in ascending order; the final result of each request carries last.
  dftn_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .empty_i   (q_empty),
    .head_i    (job_head),
    .pop_o     (pop),
    .strobe_o  (res_strobe_o),
    .action_o  (action_o),
    .dest_o    (dest_node_o),
    .payload_o (fork_payload_o),
    .count_o   (accesses_done_o),
    .last_o    (last_o)
  );

endmodule

// ===== sv/dftn_checker.sv =====
// Port-level checker for the token node, bound to the top level.
// Depends on dftn_pkg and on the ports of dining_fork_token_node.
module dftn_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          res_strobe_o,
  input logic [2:0]                    action_o,
  input logic [dftn_pkg::ID_W-1:0]     dest_node_o,
  input logic [1:0]                    fork_payload_o,
  input logic [dftn_pkg::COUNT_W-1:0]  accesses_done_o,
  input logic                          last_o
);

  // The results of one request come in consecutive cycles with one access count.
  a_run_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && !last_o) |=> (res_strobe_o && $stable(accesses_done_o)))
    else $error("result run broken or access count changed within a request");

  // An empty answer always carries last: it is the final result.
  a_none_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && action_o == dftn_pkg::ACT_NONE) |-> last_o)
    else $error("empty answer without last");

  // Access marks and empty answers carry no destination and no note.
  a_local_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && (action_o == dftn_pkg::ACT_NONE || action_o == dftn_pkg::ACT_ACCESS))
      |-> (dest_node_o == '0 && fork_payload_o == '0))
    else $error("nonzero destination or note on a local result");

  // Only a fork message carries a note.
  a_note_only_on_fork: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && action_o != dftn_pkg::ACT_FORK) |-> (fork_payload_o == '0))
    else $error("note on a result that is not a fork");

  // last never shows without the strobe.
  a_last_with_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> res_strobe_o)
    else $error("last without result strobe");

endmodule

bind dining_fork_token_node dftn_checker u_dftn_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .res_strobe_o    (res_strobe_o),
  .action_o        (action_o),
  .dest_node_o     (dest_node_o),
  .fork_payload_o  (fork_payload_o),
  .accesses_done_o (accesses_done_o),
  .last_o          (last_o)
);
